[rtl/core/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the signed integer to radix text block.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RADIX   = 16;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int SYM_W       = 8;
  localparam int ALPHA_W     = 64;
  localparam int IDX_W       = 5;               // digit stack address
  localparam int CNT_W       = 6;               // digit count, up to 32
  localparam int BITS_PER_STEP = 8;             // quotient bits per cycle
  localparam int CHUNK_W     = 2;               // width of the step counter within a digit

  localparam logic [1:0] REG_RADIX         = 2'd0;
  localparam logic [1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET         = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_W-1:0] ALPHABET_HIGH_RESET = 64'h0;
  localparam logic [SYM_W-1:0]   MINUS_SYMBOL        = 8'h2D;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } stc_cmd_t;

  typedef struct packed {
    logic step_last;
    logic quot_zero;
    logic neg;
    logic idx_zero;
    logic out_free;
  } stc_sts_t;

endpackage

[rtl/core/stc_ctrl.sv]
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: load, divide digit by digit, emit sign and digits.
// ----------------------------------------------------------------------------
module stc_ctrl import stc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     value_valid,
  output logic     value_stall,
  input  stc_sts_t sts,
  output stc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SIGN  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign value_stall = rst || (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (value_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last && sts.quot_zero) begin
          state_next = sts.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.idx_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/stc_datapath.sv]
// ----------------------------------------------------------------------------
// stc_datapath
// Config registers, shared divider, digit stack and output register.
// ----------------------------------------------------------------------------
module stc_datapath import stc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ALPHA_W-1:0]            cfg_data,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  stc_cmd_t                      cmd,
  output stc_sts_t                      sts,
  output logic                          text_valid,
  input  logic                          text_stall,
  output logic [SYM_W-1:0]              symbol,
  output logic                          last
);

  logic [RADIX_W-1:0]     radix;
  logic [ALPHA_W-1:0]     alphabet_low;
  logic [ALPHA_W-1:0]     alphabet_high;
  logic [VALUE_WIDTH-1:0] dvd;
  logic [DIGIT_W-1:0]     rem;
  logic [CHUNK_W-1:0]     chunk;
  logic                   neg;
  logic [CNT_W-1:0]       ndig;
  logic [IDX_W-1:0]       idx;
  logic [DIGIT_W-1:0]     digits [2**IDX_W];

  logic [RADIX_W-1:0]     reff;
  logic [VALUE_WIDTH-1:0] dvd_next;
  logic [DIGIT_W-1:0]     rem_next;
  logic [DIGIT_W-1:0]     cur_digit;
  logic [SYM_W-1:0]       cur_sym;
  logic                   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= RADIX_RESET;
      alphabet_low  <= ALPHABET_LOW_RESET;
      alphabet_high <= ALPHABET_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:         radix         <= cfg_data[RADIX_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix < 5'd2) begin
      reff = 5'd2;
    end else if (radix > RADIX_W'(MAX_RADIX)) begin
      reff = RADIX_W'(MAX_RADIX);
    end else begin
      reff = radix;
    end
  end

  // restoring division, eight quotient bits per cycle
  always_comb begin
    logic [RADIX_W-1:0]     t;
    logic [DIGIT_W-1:0]     r;
    logic [VALUE_WIDTH-1:0] d;
    r = rem;
    d = dvd;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {r, d[VALUE_WIDTH-1]};
      d = {d[VALUE_WIDTH-2:0], 1'b0};
      if (t >= reff) begin
        t    = t - reff;
        d[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
    dvd_next = d;
  end

  assign cur_digit = digits[idx];

  always_comb begin
    if (cur_digit[DIGIT_W-1]) begin
      cur_sym = alphabet_high[{cur_digit[DIGIT_W-2:0], 3'b000} +: SYM_W];
    end else begin
      cur_sym = alphabet_low[{cur_digit[DIGIT_W-2:0], 3'b000} +: SYM_W];
    end
  end

  assign out_free      = !text_valid || !text_stall;
  assign sts.step_last = (chunk == '1);
  assign sts.quot_zero = (dvd_next == '0);
  assign sts.neg       = neg;
  assign sts.idx_zero  = (idx == '0);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg   <= value[VALUE_WIDTH-1];
      dvd   <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      rem   <= '0;
      chunk <= '0;
      ndig  <= '0;
    end else if (cmd.div_step) begin
      chunk <= chunk + 1'b1;
      if (chunk == '1) begin
        digits[ndig[IDX_W-1:0]] <= rem_next;
        ndig <= ndig + 1'b1;
        idx  <= ndig[IDX_W-1:0];
        rem  <= '0;
      end else begin
        rem  <= rem_next;
      end
      dvd <= dvd_next;
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      text_valid <= 1'b1;
    end else if (!text_stall) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      symbol <= MINUS_SYMBOL;
      last   <= 1'b0;
    end else if (cmd.emit_digit) begin
      symbol <= cur_sym;
      last   <= (idx == '0);
    end
  end

endmodule

[rtl/core/signed_integer_to_radix_text_top.sv]
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top
// Converts a signed 32-bit value to its text in a configurable radix.
// ----------------------------------------------------------------------------
// Input channel value_valid/value_stall takes one signed value per item.
// Output channel text_valid/text_stall gives one character per item, most
// significant digit first, a leading '-' for negative values, last set on
// the final character. No terminator is sent.
// Config channel cfg_valid/cfg_ready (ready whenever out of reset) writes
// radix (0), alphabet_low (1), alphabet_high (2); other indexes are ignored.
// Write only while idle. Radix is clamped to 2..16.
// The block loads a value, then the shared divider works out its digits
// (eight quotient bits per cycle over 32 bits), then the sign and the
// digits go out one character at a time.
// The next value is taken while the final character still waits.
// A stalled receiver holds the output register and pauses emission.
// Reset (rst, synchronous) restores radix 10 and alphabet "01234567",
// digits 8 and 9 as byte 0, and empties the output register.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top import stc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ALPHA_W-1:0]            cfg_data,
  input  logic                          value_valid,
  output logic                          value_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          text_valid,
  input  logic                          text_stall,
  output logic [SYM_W-1:0]              symbol,
  output logic                          last
);

  stc_cmd_t cmd;
  stc_sts_t sts;

  assign cfg_ready = !rst;

  stc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  stc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .symbol     (symbol),
    .last       (last)
  );

endmodule

[sim/tb_signed_integer_to_radix_text_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_integer_to_radix_text_top
// Self-checking bench for the signed integer to radix text converter.
// A driver feeds signed values from a queue, a predictor expands each accepted
// value into its expected characters, and a monitor compares every character
// leaving the block against them in order. Radix and alphabet registers are
// reprogrammed between phases while the block is idle, covering the clamped
// radix settings, extreme alphabets and random value mixes under random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_text_top;
  import stc_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          END_WAIT    = 300;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [63:0] HEX_LOW     = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HEX_HIGH    = 64'h4645_4443_4241_3938;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } text_char_t;

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index   = REG_RADIX;
  logic [ALPHA_W-1:0]            cfg_data    = '0;
  logic                          value_valid = 1'b0;
  logic                          value_stall;
  logic signed [VALUE_WIDTH-1:0] value       = '0;
  logic                          text_valid;
  logic                          text_stall  = 1'b0;
  logic [SYM_W-1:0]              symbol;
  logic                          last;

  logic signed [VALUE_WIDTH-1:0] pending_values [$];
  text_char_t                    expected_text [$];

  logic [RADIX_W-1:0] radix_setting      = RADIX_RESET;
  logic [ALPHA_W-1:0] alpha_low_setting  = ALPHABET_LOW_RESET;
  logic [ALPHA_W-1:0] alpha_high_setting = ALPHABET_HIGH_RESET;

  bit quiet      = 1'b0;
  int send_gap   = 0;
  int stall_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  signed_integer_to_radix_text_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .symbol      (symbol),
    .last        (last)
  );

  always #4 clk = ~clk;

  function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_W-1:0]     base;
    logic [DIGIT_W-1:0]     digits [$];
    logic [DIGIT_W-1:0]     d;
    text_char_t             c;
    base = radix_setting;
    if (base < 2) base = 2;
    if (base > MAX_RADIX) base = RADIX_W'(MAX_RADIX);
    mag = v[VALUE_WIDTH-1] ? (~v + 32'd1) : v;
    do begin
      d = DIGIT_W'(mag % base);
      digits.push_front(d);
      mag = mag / base;
    end while (mag != 0 && digits.size() < VALUE_WIDTH);
    if (v[VALUE_WIDTH-1]) begin
      c.sym  = MINUS_SYMBOL;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    foreach (digits[k]) begin
      d = digits[k];
      c.sym  = d[3] ? alpha_high_setting[8*d[2:0] +: 8] : alpha_low_setting[8*d[2:0] +: 8];
      c.last = (k == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 40);
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'sd0;
          1: v = -32'sd1;
          2: v = 32'sd1;
          3: v = 32'sh7fff_ffff;
          default: v = 32'sh8000_0000;
        endcase
      end
      4: v = (32'sd1 <<< $urandom_range(0, 30)) + $signed($urandom_range(0, 2)) - 32'sd1;
      default: v = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [ALPHA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIX:         radix_setting = data[RADIX_W-1:0];
      REG_ALPHABET_LOW:  alpha_low_setting = data;
      REG_ALPHABET_HIGH: alpha_high_setting = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_values.size() != 0 || value_valid || expected_text.size() != 0);
  endtask

  // sender: one item in flight, random gaps only while the slot is free
  always @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else begin
      if (value_valid && !value_stall) predict_text(value);
      if (!value_valid || !value_stall) begin
        if (send_gap == 0 && !quiet && $urandom_range(0, 6) == 0)
          send_gap = $urandom_range(1, 12);
        if (send_gap > 0 && !quiet) begin
          value_valid <= 1'b0;
          send_gap--;
        end else if (pending_values.size() != 0) begin
          value_valid <= 1'b1;
          value       <= pending_values.pop_front();
        end else begin
          value_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_stall <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        if (expected_text.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected character sym=%02h last=%0b", $time, symbol, last);
        end else begin
          want = expected_text.pop_front();
          if (symbol !== want.sym || last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp sym=%02h last=%0b got sym=%02h last=%0b",
                       $time, want.sym, want.last, symbol, last);
          end
        end
      end
      if (quiet) begin
        stall_left = 0;
        text_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        text_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        text_stall <= 1'b1;
      end else begin
        text_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    static logic signed [VALUE_WIDTH-1:0] decimal_cases [9] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd89, 32'sd10, 32'sh7fff_ffff, 32'sh8000_0000,
      32'sd1234567890, -32'sd98765
    };
    logic [RADIX_W-1:0] phase_radix;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: radix 10, digits 8 and 9 map to byte 0
    foreach (decimal_cases[i]) pending_values.push_back(decimal_cases[i]);
    wait_drained();

    write_reg(REG_RADIX, 64'd16);
    write_reg(REG_ALPHABET_LOW, HEX_LOW);
    write_reg(REG_ALPHABET_HIGH, HEX_HIGH);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sh7fff_ffff);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sd255);
    wait_drained();

    // longest text: minus plus 32 binary digits
    write_reg(REG_RADIX, 64'd2);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sd5);
    wait_drained();

    // clamped radix settings
    write_reg(REG_RADIX, 64'd0);
    pending_values.push_back(32'sd6);
    wait_drained();
    write_reg(REG_RADIX, 64'd1);
    pending_values.push_back(-32'sd3);
    wait_drained();
    write_reg(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ALPHABET_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ALPHABET_HIGH, 64'h0);
    pending_values.push_back(32'sh0000_DEAD);
    wait_drained();
    write_reg(REG_RADIX, 64'd17);
    write_reg(REG_ALPHABET_LOW, 64'h0);
    write_reg(REG_ALPHABET_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    pending_values.push_back(-32'sd1000);
    wait_drained();

    // unused index must leave the settings alone
    write_reg(REG_RADIX, 64'd3);
    write_reg(REG_ALPHABET_LOW, {$urandom, $urandom});
    write_reg(REG_UNUSED, {$urandom, $urandom});
    pending_values.push_back(32'sd0);
    pending_values.push_back(-32'sd80);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: phase_radix = 5'd2;
        1: phase_radix = 5'd16;
        2: phase_radix = RADIX_W'($urandom_range(3, 15));
        3: phase_radix = RADIX_W'($urandom_range(0, 31));
        4: phase_radix = 5'd10;
        default: phase_radix = RADIX_W'($urandom_range(2, 16));
      endcase
      write_reg(REG_RADIX, {$urandom, 27'd0, phase_radix});
      write_reg(REG_ALPHABET_LOW, {$urandom, $urandom});
      write_reg(REG_ALPHABET_HIGH, {$urandom, $urandom});
      if (phase == 5) quiet = 1'b1;
      for (int n = 0; n < 18; n++) begin
        pending_values.push_back(random_value());
        if (phase == 2 && n == 10) wait_drained();
      end
      wait_drained();
    end

    repeat (END_WAIT) @(posedge clk);
    if (expected_text.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/stc_pkg.sv
rtl/core/stc_ctrl.sv
rtl/core/stc_datapath.sv
rtl/core/signed_integer_to_radix_text_top.sv
sim/tb_signed_integer_to_radix_text_top.sv
